/* sv/sm4cbc_pkg.sv */
// ----------------------------------------------------------------------------
// SM4 CBC cipher package
// Shared constants, S-box, round-key memory write port and helper functions.
// ----------------------------------------------------------------------------
package sm4cbc_pkg;

  localparam int ROUND_COUNT = 32;
  localparam int RK_AW       = $clog2(ROUND_COUNT);
  localparam int CFG_IDX_W   = 3;

  typedef logic [RK_AW-1:0] rk_addr_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 3'd4;

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  typedef struct packed {
    logic        en;
    rk_addr_t    addr;
    logic [31:0] data;
  } rk_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] sub_word(input logic [31:0] a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  // CK word i: byte j (msb first) is (4*i+j)*7 mod 256
  function automatic logic [31:0] ck_word(input rk_addr_t i);
    logic [7:0]  base;
    logic [7:0]  b;
    logic [15:0] prod;
    logic [31:0] w;
    base = {1'b0, i, 2'b00};
    w    = '0;
    for (int j = 0; j < 4; j++) begin
      b    = base + 8'(j);
      prod = {8'd0, b} * 16'd7;
      w    = {w[23:0], prod[7:0]};
    end
    return w;
  endfunction

endpackage

/* sv/sm4cbc_if.sv */
// ----------------------------------------------------------------------------
// SM4 CBC cipher channel interfaces
// Block request, block result and configuration write channels.
// ----------------------------------------------------------------------------
interface sm4cbc_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic        chain_start;
  modport source (output valid, data_high, data_low, chain_start, input ready);
  modport sink (input valid, data_high, data_low, chain_start, output ready);
endinterface

interface sm4cbc_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

interface sm4cbc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [sm4cbc_pkg::CFG_IDX_W-1:0]   index;
  logic [63:0]                        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/sm4cbc_key_ram.sv */
// ----------------------------------------------------------------------------
// SM4 round-key memory
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module sm4cbc_key_ram (
  input  logic                 clk,
  input  sm4cbc_pkg::rk_wr_t   wr,
  input  sm4cbc_pkg::rk_addr_t rd_addr,
  output logic [31:0]          rd_data
);

  logic [31:0] mem [sm4cbc_pkg::ROUND_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/sm4cbc_round.sv */
// ----------------------------------------------------------------------------
// SM4 shared round unit
// One T transform, serving both key schedule and cipher rounds.
// ----------------------------------------------------------------------------
module sm4cbc_round (
  input  logic        key_sched,
  input  logic [31:0] w0,
  input  logic [31:0] w1,
  input  logic [31:0] w2,
  input  logic [31:0] w3,
  input  logic [31:0] rk,
  output logic [31:0] nx
);

  logic [31:0] b;
  logic [31:0] lin_d;
  logic [31:0] lin_k;

  assign b = sm4cbc_pkg::sub_word(w1 ^ w2 ^ w3 ^ rk);

  assign lin_d = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
               ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  assign lin_k = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};

  assign nx = w0 ^ (key_sched ? lin_k : lin_d);

endmodule

/* sv/sm4_cbc_cipher_unit.sv */
// ----------------------------------------------------------------------------
// SM4 CBC cipher unit
// Flow: an accepted request beat passes ST_SETUP, ST_CRYPT and ST_DONE, which
//   loads the result; a key write adds key expansion (ST_KEXP) first.
// Throughput: one block at a time, set by the single shared round unit doing
//   one round per cycle over 32 rounds; a new request is accepted only in
//   ST_IDLE, and a result held by the sink stalls the handoff and the input.
// Reset: synchronous, clears key, IV, mode, chaining value and control;
//   the round-key memory needs no clearing pass.
// ----------------------------------------------------------------------------
module sm4_cbc_cipher_unit (
  input  logic          clk,
  input  logic          rst,
  sm4cbc_cfg_if.sink    cfg,
  sm4cbc_req_if.sink    req,
  sm4cbc_rsp_if.source  rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_KEXP,
    ST_CRYPT,
    ST_DONE
  } state_t;

  localparam sm4cbc_pkg::rk_addr_t LAST_ROUND =
    sm4cbc_pkg::rk_addr_t'(sm4cbc_pkg::ROUND_COUNT - 1);

  state_t               state;
  sm4cbc_pkg::rk_addr_t cnt;
  logic [31:0]          x0, x1, x2, x3;
  logic [63:0]          key_high, key_low, iv_high, iv_low;
  logic                 decrypt_mode;
  logic                 keys_ready;
  logic [63:0]          chain_high, chain_low;
  logic [63:0]          din_high, din_low;
  logic [63:0]          res_high, res_low;
  logic                 rsp_valid;
  logic [63:0]          rsp_high, rsp_low;

  logic                 key_sched;
  logic [31:0]          rk_op;
  logic [31:0]          rk_q;
  logic [31:0]          nx;
  sm4cbc_pkg::rk_wr_t   rk_wr;
  sm4cbc_pkg::rk_addr_t rd_idx;
  sm4cbc_pkg::rk_addr_t rd_addr;
  logic [63:0]          blk_high, blk_low;

  assign key_sched = (state == ST_KEXP);
  assign rk_op     = key_sched ? sm4cbc_pkg::ck_word(cnt) : rk_q;

  sm4cbc_round u_round (
    .key_sched (key_sched),
    .w0        (x0),
    .w1        (x1),
    .w2        (x2),
    .w3        (x3),
    .rk        (rk_op),
    .nx        (nx)
  );

  // prefetch the key of the next round; decryption walks the keys backward
  assign rd_idx  = (state == ST_SETUP) ? '0 : cnt + sm4cbc_pkg::rk_addr_t'(1);
  assign rd_addr = decrypt_mode ? ~rd_idx : rd_idx;

  assign rk_wr.en   = key_sched;
  assign rk_wr.addr = cnt;
  assign rk_wr.data = nx;

  sm4cbc_key_ram u_key_ram (
    .clk     (clk),
    .wr      (rk_wr),
    .rd_addr (rd_addr),
    .rd_data (rk_q)
  );

  assign blk_high = {nx, x3};
  assign blk_low  = {x2, x1};

  assign cfg.ready       = 1'b1;
  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.result_high = rsp_high;
  assign rsp.result_low  = rsp_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      key_high     <= '0;
      key_low      <= '0;
      iv_high      <= '0;
      iv_low       <= '0;
      decrypt_mode <= 1'b0;
      keys_ready   <= 1'b0;
      chain_high   <= '0;
      chain_low    <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          sm4cbc_pkg::CFG_KEY_HIGH: begin
            key_high   <= cfg.data;
            keys_ready <= 1'b0;
          end
          sm4cbc_pkg::CFG_KEY_LOW: begin
            key_low    <= cfg.data;
            keys_ready <= 1'b0;
          end
          sm4cbc_pkg::CFG_IV_HIGH:      iv_high      <= cfg.data;
          sm4cbc_pkg::CFG_IV_LOW:       iv_low       <= cfg.data;
          sm4cbc_pkg::CFG_DECRYPT_MODE: decrypt_mode <= cfg.data[0];
          default: ;
        endcase
      end

      // the handoff below refills the register itself
      if (rsp_valid && rsp.ready && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            din_high <= req.data_high;
            din_low  <= req.data_low;
            if (req.chain_start) begin
              chain_high <= iv_high;
              chain_low  <= iv_low;
            end
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          cnt <= '0;
          if (!keys_ready) begin
            x0    <= key_high[63:32] ^ sm4cbc_pkg::FK0;
            x1    <= key_high[31:0]  ^ sm4cbc_pkg::FK1;
            x2    <= key_low[63:32]  ^ sm4cbc_pkg::FK2;
            x3    <= key_low[31:0]   ^ sm4cbc_pkg::FK3;
            state <= ST_KEXP;
          end else if (decrypt_mode) begin
            {x0, x1} <= din_high;
            {x2, x3} <= din_low;
            state    <= ST_CRYPT;
          end else begin
            {x0, x1} <= din_high ^ chain_high;
            {x2, x3} <= din_low ^ chain_low;
            state    <= ST_CRYPT;
          end
        end
        ST_KEXP: begin
          x0  <= x1;
          x1  <= x2;
          x2  <= x3;
          x3  <= nx;
          cnt <= cnt + sm4cbc_pkg::rk_addr_t'(1);
          if (cnt == LAST_ROUND) begin
            keys_ready <= 1'b1;
            state      <= ST_SETUP;
          end
        end
        ST_CRYPT: begin
          x0  <= x1;
          x1  <= x2;
          x2  <= x3;
          x3  <= nx;
          cnt <= cnt + sm4cbc_pkg::rk_addr_t'(1);
          if (cnt == LAST_ROUND) begin
            if (decrypt_mode) begin
              res_high   <= blk_high ^ chain_high;
              res_low    <= blk_low ^ chain_low;
              chain_high <= din_high;
              chain_low  <= din_low;
            end else begin
              res_high   <= blk_high;
              res_low    <= blk_low;
              chain_high <= blk_high;
              chain_low  <= blk_low;
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the result register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_high  <= res_high;
            rsp_low   <= res_low;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_crypt_needs_keys: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CRYPT) |-> keys_ready)
    else $error("cipher round ran without expanded keys");

  a_accept_to_setup: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_SETUP))
    else $error("accepted beat did not start setup");

  a_last_round_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CRYPT && cnt == LAST_ROUND) |=> (state == ST_DONE))
    else $error("last cipher round did not hand off the result");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_DONE))
    else $error("result valid raised outside handoff");

endmodule
